[hdl/obmc_wb_pkg.sv]
// Shared types, weight window ROM and blend rule codes for the window blend core.
package obmc_wb_pkg;

	localparam int SampleW = 16;
	localparam int WeightW = 5;
	localparam int ProdW   = SampleW + WeightW + 1;
	localparam int AccW    = ProdW + 1;
	localparam int FinRnd  = 8;
	localparam int FinSh   = 4;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic [WeightW-1:0]        weight_t;

	typedef enum logic [1:0] {
		MODE_INIT,
		MODE_ACC,
		MODE_FIN,
		MODE_COPY
	} mode_t;

	typedef struct packed {
		logic    skip;
		mode_t   mode;
		weight_t weight;
	} ctrl_t;

	// Upper half of the symmetric 16x16 window, one row per entry.
	localparam logic [3:0] WROM [8][16] = '{
		'{4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1,
		  4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2,
		  4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0},
		'{4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4,
		  4'd4, 4'd4, 4'd3, 4'd2, 4'd2, 4'd1, 4'd1, 4'd0},
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd6,
		  4'd6, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
		'{4'd1, 4'd1, 4'd2, 4'd4, 4'd5, 4'd7, 4'd8, 4'd9,
		  4'd9, 4'd8, 4'd7, 4'd5, 4'd4, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd9, 4'd11,
		  4'd11, 4'd9, 4'd9, 4'd7, 4'd5, 4'd3, 4'd2, 4'd1},
		'{4'd1, 4'd2, 4'd4, 4'd6, 4'd8, 4'd9, 4'd12, 4'd13,
		  4'd13, 4'd12, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2, 4'd1},
		'{4'd1, 4'd2, 4'd4, 4'd6, 4'd9, 4'd11, 4'd13, 4'd14,
		  4'd14, 4'd13, 4'd11, 4'd9, 4'd6, 4'd4, 4'd2, 4'd1}
	};

	function automatic logic [3:0] wrom_lookup(input logic [2:0] j, input logic [3:0] c);
		return WROM[j][c];
	endfunction

endpackage

[hdl/obmc_window_blend_core.sv]
// Top level of the overlapped-window pixel blend core: input and result registers.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  command | start / busy       | ref_sample_a/b, use_average, dest_pixel,
//          |                    | win_row, win_col, edge_top/bottom/left/right
//  result  | done (one cycle)   | new_pixel, write_enable
//
// One pixel per clock; busy is never raised. A command's result shows with done
// after it passes the input register and then the result register, which sit
// around the decode and multiply-add logic. Reset clears only the valid flags.
// The result side cannot stall, so no result is ever held back.
module obmc_window_blend_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  obmc_wb_pkg::sample_t ref_sample_a,
	input  obmc_wb_pkg::sample_t ref_sample_b,
	input  logic                 use_average,
	input  obmc_wb_pkg::sample_t dest_pixel,
	input  logic [3:0]           win_row,
	input  logic [3:0]           win_col,
	input  logic                 edge_top,
	input  logic                 edge_bottom,
	input  logic                 edge_left,
	input  logic                 edge_right,
	output logic                 done,
	output obmc_wb_pkg::sample_t new_pixel,
	output logic                 write_enable
);
	import obmc_wb_pkg::*;

	logic       valid_s1;
	sample_t    ref_a_s1;
	sample_t    ref_b_s1;
	logic       use_avg_s1;
	sample_t    dest_s1;
	logic [3:0] row_s1;
	logic [3:0] col_s1;
	logic [3:0] edges_s1;
	ctrl_t      ctrl;
	sample_t    pixel_d;
	logic       we_d;
	logic       accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done     <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ref_a_s1   <= ref_sample_a;
			ref_b_s1   <= ref_sample_b;
			use_avg_s1 <= use_average;
			dest_s1    <= dest_pixel;
			row_s1     <= win_row;
			col_s1     <= win_col;
			edges_s1   <= {edge_top, edge_bottom, edge_left, edge_right};
		end
		if (valid_s1) begin
			new_pixel    <= pixel_d;
			write_enable <= we_d;
		end
	end

	obmc_wb_decode u_decode (
		.edge_top    (edges_s1[3]),
		.edge_bottom (edges_s1[2]),
		.edge_left   (edges_s1[1]),
		.edge_right  (edges_s1[0]),
		.win_row     (row_s1),
		.win_col     (col_s1),
		.ctrl        (ctrl)
	);

	obmc_wb_datapath u_datapath (
		.ref_sample_a (ref_a_s1),
		.ref_sample_b (ref_b_s1),
		.use_average  (use_avg_s1),
		.dest_pixel   (dest_s1),
		.ctrl         (ctrl),
		.new_pixel    (pixel_d),
		.write_enable (we_d)
	);

	a_one_result_per_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("accepted pixel produced no result strobe");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without an accepted pixel");

	a_skip_keeps_dest: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctrl.skip |=> !write_enable && new_pixel == $past(dest_s1))
		else $error("skipped pixel did not pass the destination value through");

endmodule

[hdl/obmc_wb_decode.sv]
// Window position and edge flag decode: skip, blend rule and folded weight.
module obmc_wb_decode (
	input  logic                 edge_top,
	input  logic                 edge_bottom,
	input  logic                 edge_left,
	input  logic                 edge_right,
	input  logic [3:0]           win_row,
	input  logic [3:0]           win_col,
	output obmc_wb_pkg::ctrl_t   ctrl
);
	import obmc_wb_pkg::*;

	logic       upper;
	logic       left;
	logic [2:0] j;
	logic       vedge;
	logic       hedge;
	logic [3:0] w_own;
	logic [3:0] w_vert;
	logic [3:0] w_horz;

	assign upper = ~win_row[3];
	assign left  = ~win_col[3];
	// rows 8..15 mirror onto 7..0
	assign j     = upper ? win_row[2:0] : ~win_row[2:0];
	assign vedge = upper ? edge_top : edge_bottom;
	assign hedge = left ? edge_left : edge_right;

	assign w_own  = wrom_lookup(j, win_col);
	assign w_vert = wrom_lookup(~j, win_col);
	assign w_horz = wrom_lookup(j, {~win_col[3], win_col[2:0]});

	always_comb begin
		ctrl.skip = (edge_top && win_row[3:2] == 2'b00)
			|| (edge_bottom && win_row[3:2] == 2'b11)
			|| (edge_left && win_col[3:2] == 2'b00)
			|| (edge_right && win_col[3:2] == 2'b11);
		ctrl.weight = {1'b0, w_own};
		priority if (vedge && hedge) begin
			ctrl.mode = MODE_COPY;
		end else if (vedge) begin
			ctrl.weight = {1'b0, w_own} + {1'b0, w_vert};
			ctrl.mode   = left ? MODE_FIN : MODE_INIT;
		end else if (hedge) begin
			ctrl.weight = {1'b0, w_own} + {1'b0, w_horz};
			ctrl.mode   = upper ? MODE_FIN : MODE_INIT;
		end else begin
			unique case ({upper, left})
				2'b11:   ctrl.mode = MODE_FIN;
				2'b10:   ctrl.mode = MODE_ACC;
				2'b01:   ctrl.mode = MODE_ACC;
				default: ctrl.mode = MODE_INIT;
			endcase
		end
	end

endmodule

[hdl/obmc_wb_datapath.sv]
// Source select, weight multiply and init/accumulate/finalize arithmetic.
module obmc_wb_datapath (
	input  obmc_wb_pkg::sample_t ref_sample_a,
	input  obmc_wb_pkg::sample_t ref_sample_b,
	input  logic                 use_average,
	input  obmc_wb_pkg::sample_t dest_pixel,
	input  obmc_wb_pkg::ctrl_t   ctrl,
	output obmc_wb_pkg::sample_t new_pixel,
	output logic                 write_enable
);
	import obmc_wb_pkg::*;

	logic signed [SampleW:0]   pair_sum;
	sample_t                   src;
	logic signed [ProdW-1:0]   prod;
	logic signed [AccW-1:0]    acc;
	logic signed [AccW-1:0]    fin_sum;

	assign pair_sum = {ref_sample_a[SampleW-1], ref_sample_a}
		+ {ref_sample_b[SampleW-1], ref_sample_b};
	// floored average: arithmetic shift of the 17-bit sum
	assign src  = use_average ? pair_sum[SampleW:1] : ref_sample_a;
	assign prod = src * $signed({1'b0, ctrl.weight});
	assign acc  = {{(AccW-SampleW){dest_pixel[SampleW-1]}}, dest_pixel}
		+ {prod[ProdW-1], prod};
	assign fin_sum = acc + AccW'(FinRnd);

	always_comb begin
		write_enable = ~ctrl.skip;
		if (ctrl.skip) begin
			new_pixel = dest_pixel;
		end else begin
			unique case (ctrl.mode)
				MODE_INIT: new_pixel = prod[SampleW-1:0];
				MODE_ACC:  new_pixel = acc[SampleW-1:0];
				MODE_FIN:  new_pixel = fin_sum[SampleW+FinSh-1:FinSh];
				default:   new_pixel = src;
			endcase
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the overlapped-window pixel blend core.
module testbench;
	import obmc_wb_pkg::*;

	localparam int STALL_LIMIT   = 200;
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_PIXELS = 1126;
	localparam int CALM_TAIL     = 150;
	localparam int MAX_REPORTS   = 10;

	// Upper half of the symmetric blend window; lower rows mirror these.
	localparam int WIN_WEIGHTS [8][16] = '{
		'{0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0},
		'{0, 0, 1, 1, 1, 2, 2, 2, 2, 2, 2, 1, 1, 1, 0, 0},
		'{0, 1, 1, 2, 2, 3, 4, 4, 4, 4, 3, 2, 2, 1, 1, 0},
		'{0, 1, 2, 3, 4, 5, 6, 6, 6, 6, 5, 4, 3, 2, 1, 0},
		'{1, 1, 2, 4, 5, 7, 8, 9, 9, 8, 7, 5, 4, 2, 1, 1},
		'{1, 2, 3, 5, 7, 9, 9, 11, 11, 9, 9, 7, 5, 3, 2, 1},
		'{1, 2, 4, 6, 8, 9, 12, 13, 13, 12, 9, 8, 6, 4, 2, 1},
		'{1, 2, 4, 6, 9, 11, 13, 14, 14, 13, 11, 9, 6, 4, 2, 1}
	};

	typedef struct packed {
		sample_t    ref_a;
		sample_t    ref_b;
		logic       avg;
		sample_t    dest;
		logic [3:0] row;
		logic [3:0] col;
		logic       e_top;
		logic       e_bot;
		logic       e_left;
		logic       e_right;
	} pix_cmd_t;

	typedef struct packed {
		sample_t pixel;
		logic    wr;
	} pix_res_t;

	class blend_scoreboard;
		pix_res_t expected_pixels[$];
		int rule_count [4];
		int skip_count;
		int commands;
		int results;
		int mismatches;

		function pix_res_t predict_blend(pix_cmd_t c);
			int src, dst, wt, row_j, val;
			logic upper, left_half, vedge, hedge;
			mode_t rule;
			pix_res_t r;
			src = $signed(c.ref_a);
			if (c.avg)
				src = (src + $signed(c.ref_b)) >>> 1;
			dst = $signed(c.dest);
			upper = c.row < 4'd8;
			left_half = c.col < 4'd8;
			row_j = upper ? int'(c.row) : 15 - int'(c.row);
			vedge = upper ? c.e_top : c.e_bot;
			hedge = left_half ? c.e_left : c.e_right;
			wt = WIN_WEIGHTS[row_j][c.col];
			if ((c.e_top && c.row < 4) || (c.e_bot && c.row >= 12) ||
			    (c.e_left && c.col < 4) || (c.e_right && c.col >= 12)) begin
				skip_count++;
				r.pixel = c.dest;
				r.wr = 1'b0;
				return r;
			end
			if (vedge && hedge) begin
				rule = MODE_COPY;
			end else if (vedge) begin
				// missing vertical neighbour folds in the mirrored row
				wt += WIN_WEIGHTS[7 - row_j][c.col];
				rule = left_half ? MODE_FIN : MODE_INIT;
			end else if (hedge) begin
				// missing horizontal neighbour folds in the column eight away
				wt += WIN_WEIGHTS[row_j][c.col ^ 4'd8];
				rule = upper ? MODE_FIN : MODE_INIT;
			end else if (upper) begin
				rule = left_half ? MODE_FIN : MODE_ACC;
			end else begin
				rule = left_half ? MODE_ACC : MODE_INIT;
			end
			case (rule)
				MODE_FIN:  val = (dst + src * wt + 8) >>> 4;
				MODE_ACC:  val = dst + src * wt;
				MODE_INIT: val = src * wt;
				default:   val = src;
			endcase
			rule_count[rule]++;
			r.pixel = sample_t'(val);
			r.wr = 1'b1;
			return r;
		endfunction

		function void note_command(pix_cmd_t c);
			commands++;
			expected_pixels.push_back(predict_blend(c));
		endfunction

		function void check_result(sample_t px, logic wr);
			pix_res_t want;
			results++;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: result pixel %0d we %b with nothing pending", px, wr);
				return;
			end
			want = expected_pixels.pop_front();
			if (px !== want.pixel || wr !== want.wr) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch at result %0d: expected pixel %0d we %b, got pixel %0d we %b",
						results, want.pixel, want.wr, px, wr);
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	pix_cmd_t cmd_drv = '0;
	logic     busy;
	logic     done;
	sample_t  new_pixel;
	logic     write_enable;
	int       stall_cycles = 0;
	blend_scoreboard blend_sb = new;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	obmc_window_blend_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.ref_sample_a (cmd_drv.ref_a),
		.ref_sample_b (cmd_drv.ref_b),
		.use_average  (cmd_drv.avg),
		.dest_pixel   (cmd_drv.dest),
		.win_row      (cmd_drv.row),
		.win_col      (cmd_drv.col),
		.edge_top     (cmd_drv.e_top),
		.edge_bottom  (cmd_drv.e_bot),
		.edge_left    (cmd_drv.e_left),
		.edge_right   (cmd_drv.e_right),
		.done         (done),
		.new_pixel    (new_pixel),
		.write_enable (write_enable)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				blend_sb.note_command(cmd_drv);
			if (done)
				blend_sb.check_result(new_pixel, write_enable);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	function automatic pix_cmd_t pixel_cmd(int a, int b, bit avg, int d, int r, int c,
			bit t, bit bo, bit l, bit rt);
		pix_cmd_t p;
		p.ref_a = sample_t'(a);
		p.ref_b = sample_t'(b);
		p.avg = avg;
		p.dest = sample_t'(d);
		p.row = 4'(r);
		p.col = 4'(c);
		p.e_top = t;
		p.e_bot = bo;
		p.e_left = l;
		p.e_right = rt;
		return p;
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return sample_t'(int'($urandom_range(0, 255)) - 128);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic pix_cmd_t rand_cmd();
		pix_cmd_t p;
		p.ref_a = rand_sample();
		p.ref_b = rand_sample();
		p.avg = 1'($urandom_range(0, 1));
		p.dest = rand_sample();
		p.row = 4'($urandom_range(0, 15));
		p.col = 4'($urandom_range(0, 15));
		p.e_top = $urandom_range(0, 3) == 0;
		p.e_bot = $urandom_range(0, 3) == 0;
		p.e_left = $urandom_range(0, 3) == 0;
		p.e_right = $urandom_range(0, 3) == 0;
		return p;
	endfunction

	task automatic issue(input pix_cmd_t c);
		cmd_drv <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// start low with junk on the payload, which must be ignored
	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) begin
			cmd_drv <= rand_cmd();
			@(posedge clk);
		end
	endtask

	initial begin
		int gap_odds;
		gap_odds = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// interior rules per quadrant, extremes, floor of negative averages
		issue(pixel_cmd(32767, 0, 0, -32768, 7, 7, 0, 0, 0, 0));
		issue(pixel_cmd(-32768, -32767, 1, 1234, 7, 8, 0, 0, 0, 0));
		issue(pixel_cmd(32767, 32767, 1, 32767, 8, 7, 0, 0, 0, 0));
		issue(pixel_cmd(-32767, 0, 0, 0, 8, 8, 0, 0, 0, 0));
		issue(pixel_cmd(-1, 0, 0, -1, 0, 0, 0, 0, 0, 0));
		// single edge folds
		issue(pixel_cmd(1000, 0, 0, -500, 5, 3, 1, 0, 0, 0));
		issue(pixel_cmd(-2000, 77, 0, 300, 4, 10, 1, 0, 0, 0));
		issue(pixel_cmd(12345, -3, 1, -9, 10, 2, 0, 1, 0, 0));
		issue(pixel_cmd(-12345, 0, 0, 5, 11, 13, 0, 1, 0, 0));
		issue(pixel_cmd(321, 0, 0, -321, 2, 5, 0, 0, 1, 0));
		issue(pixel_cmd(-321, 0, 0, 11, 9, 6, 0, 0, 1, 0));
		issue(pixel_cmd(4000, 0, 0, 100, 1, 11, 0, 0, 0, 1));
		issue(pixel_cmd(-4000, -1, 1, -100, 14, 9, 0, 0, 0, 1));
		// corner copies
		issue(pixel_cmd(-32768, 0, 0, 555, 6, 6, 1, 0, 1, 0));
		issue(pixel_cmd(32767, 32766, 1, 0, 4, 11, 1, 0, 0, 1));
		issue(pixel_cmd(-7, 0, 0, 0, 11, 4, 0, 1, 1, 0));
		issue(pixel_cmd(99, 0, 0, 0, 11, 11, 0, 1, 0, 1));
		// skipped border pixels
		issue(pixel_cmd(5, 0, 0, -32768, 0, 7, 1, 0, 0, 0));
		issue(pixel_cmd(5, 0, 0, 32767, 15, 7, 0, 1, 0, 0));
		issue(pixel_cmd(5, 0, 0, -1, 7, 0, 0, 0, 1, 0));
		issue(pixel_cmd(5, 0, 0, 42, 8, 15, 0, 0, 0, 1));
		issue(pixel_cmd(-5, 3, 1, 17, 3, 3, 1, 1, 1, 1));
		// flags for the far side have no effect
		issue(pixel_cmd(-100, 50, 1, -8, 5, 5, 0, 1, 0, 1));
		issue(pixel_cmd(777, 0, 0, 3, 13, 13, 1, 0, 1, 0));

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i % 100 == 0)
				gap_odds = $urandom_range(0, 8);
			if (i < RANDOM_PIXELS - CALM_TAIL && gap_odds != 0 &&
			    $urandom_range(0, gap_odds) == 0)
				pause($urandom_range(1, 15));
			issue(rand_cmd());
		end
		start <= 1'b0;
		@(posedge clk);
		while (blend_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d pixels blended, %0d results checked, %0d mismatches",
			blend_sb.commands, blend_sb.results, blend_sb.mismatches);
		$display("rules hit: init %0d, acc %0d, fin %0d, copy %0d, skipped %0d",
			blend_sb.rule_count[MODE_INIT], blend_sb.rule_count[MODE_ACC],
			blend_sb.rule_count[MODE_FIN], blend_sb.rule_count[MODE_COPY],
			blend_sb.skip_count);
		if (blend_sb.mismatches == 0 && blend_sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
